### hw/rtl/epuf_pkg.sv
// Package for the Euler path union-find checker.
// Holds widths, node count, the result type and the id-to-node mapping.
// Depends on nothing.
`timescale 1ns / 1ps

package epuf_pkg;

    localparam int ID_W   = 16;
    localparam int CNT_W  = 17;
    localparam int NODES  = 65536;
    localparam int NODE_W = (NODES > 2) ? $clog2(NODES) : 1;
    localparam int UW     = (NODE_W > CNT_W) ? NODE_W : CNT_W;

    // Ids are reduced by repeated compare and subtract only when the node count
    // is below the id range and is not a power of two.
    localparam bit RED_NEEDED = (NODES < (1 << ID_W)) && ((NODES & (NODES - 1)) != 0);
    localparam int RED_STEPS  = (NODE_W <= ID_W) ? (ID_W + 1 - NODE_W) : 1;
    localparam int K_W        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [UW-1:0]     uval_t;
    typedef logic [K_W-1:0]    kidx_t;

    localparam node_t NODE_LAST = NODE_W'(NODES - 1);
    localparam uval_t NODES_U   = UW'(NODES);
    localparam kidx_t K_FIRST   = K_W'(RED_STEPS - 1);

    typedef struct packed {
        logic possible;
        cnt_t components;
        cnt_t odd_nodes;
    } res_t;

    function automatic node_t node_of(input logic [ID_W-1:0] id);
        return NODE_W'(id);
    endfunction

endpackage

### hw/rtl/epuf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module epuf_ram #(
    parameter int AW = 1,
    parameter int DW = 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/epuf_unit.sv
// Shared compare and subtract unit of the checker sequencer.
// Depends on epuf_pkg.
`timescale 1ns / 1ps

module epuf_unit
    import epuf_pkg::*;
(
    input  uval_t x,
    input  uval_t y,
    output logic  eq,
    output logic  ge,
    output uval_t diff
);

    logic borrow;

    assign {borrow, diff} = {1'b0, x} - {1'b0, y};
    assign ge = !borrow;
    assign eq = (x == y);

endmodule

### hw/rtl/epuf_core.sv
// Sequencer of the checker: node flag and parent link memories, the find and
// compress walks, and the counters. Depends on epuf_pkg, epuf_ram, epuf_unit.
`timescale 1ns / 1ps

module epuf_core
    import epuf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            edge_valid,
    input  logic [ID_W-1:0] end_a,
    input  logic [ID_W-1:0] end_b,
    output logic            ready,
    output logic            res_valid,
    output res_t            res,
    input  logic            res_take
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RED, S_TA_RD, S_TA_WR, S_TB_RD, S_TB_WR,
        S_F_RD, S_F_STEP, S_C_START, S_C_STEP, S_UNION, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    node_t           clr_reg, clr_next;
    uval_t           red_val_reg, red_val_next;
    kidx_t           red_k_reg, red_k_next;
    logic            red_sel_reg, red_sel_next;
    logic [ID_W-1:0] b_raw_reg, b_raw_next;
    node_t           a_reg, a_next;
    node_t           b_reg, b_next;
    node_t           cur_reg, cur_next;
    node_t           root_reg, root_next;
    node_t           ra_reg, ra_next;
    logic            sel_reg, sel_next;
    cnt_t            distinct_reg, distinct_next;
    cnt_t            unions_reg, unions_next;
    cnt_t            odd_reg, odd_next;

    logic       fl_we;
    node_t      fl_waddr, fl_raddr;
    logic [1:0] fl_wdata, fl_rdata;
    logic       pl_we;
    node_t      pl_waddr, pl_wdata, pl_raddr, pl_rdata;

    uval_t ux, uy, udiff, red_v, shift_val;
    logic  ueq, uge, new_par;
    node_t t_node;
    cnt_t  comps;

    epuf_ram #(.AW(NODE_W), .DW(2)) u_flags (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    epuf_ram #(.AW(NODE_W), .DW(NODE_W)) u_links (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    epuf_unit u_unit (
        .x    (ux),
        .y    (uy),
        .eq   (ueq),
        .ge   (uge),
        .diff (udiff)
    );

    assign shift_val = NODES_U << red_k_reg;
    assign red_v     = uge ? udiff : red_val_reg;
    assign t_node    = (state_reg == S_TA_WR) ? a_reg : b_reg;
    assign new_par   = !fl_rdata[0];
    assign comps     = CNT_W'(udiff);

    always_comb
    begin
        ux = UW'(cur_reg);
        uy = UW'(root_reg);
        case (state_reg)
            S_RED:
            begin
                ux = red_val_reg;
                uy = shift_val;
            end
            S_F_STEP:
            begin
                ux = UW'(pl_rdata);
                uy = UW'(cur_reg);
            end
            S_C_STEP:
            begin
                ux = UW'(pl_rdata);
                uy = UW'(root_reg);
            end
            S_UNION:
            begin
                ux = UW'(ra_reg);
                uy = UW'(root_reg);
            end
            S_DONE:
            begin
                ux = UW'(distinct_reg);
                uy = UW'(unions_reg);
            end
            default:
            begin
                ux = UW'(cur_reg);
                uy = UW'(root_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        red_val_next  = red_val_reg;
        red_k_next    = red_k_reg;
        red_sel_next  = red_sel_reg;
        b_raw_next    = b_raw_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        ra_next       = ra_reg;
        sel_next      = sel_reg;
        distinct_next = distinct_reg;
        unions_next   = unions_reg;
        odd_next      = odd_reg;
        ready         = 1'b0;
        res_valid     = 1'b0;
        fl_we         = 1'b0;
        fl_waddr      = t_node;
        fl_wdata      = {1'b1, new_par};
        fl_raddr      = b_reg;
        pl_we         = 1'b0;
        pl_waddr      = cur_reg;
        pl_wdata      = root_reg;
        pl_raddr      = cur_reg;
        res.possible   = (comps <= CNT_W'(1)) && (odd_reg <= CNT_W'(2));
        res.components = comps;
        res.odd_nodes  = odd_reg;

        case (state_reg)
            S_CLEAR:
            begin
                fl_we    = 1'b1;
                fl_waddr = clr_reg;
                fl_wdata = 2'b00;
                if (clr_reg == NODE_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + node_t'(1);
                end
            end
            S_IDLE:
            begin
                ready = 1'b1;
                if (edge_valid)
                begin
                    if (RED_NEEDED)
                    begin
                        red_val_next = UW'(end_a);
                        b_raw_next   = end_b;
                        red_k_next   = K_FIRST;
                        red_sel_next = 1'b0;
                        state_next   = S_RED;
                    end
                    else
                    begin
                        a_next     = node_of(end_a);
                        b_next     = node_of(end_b);
                        state_next = S_TA_RD;
                    end
                end
            end
            S_RED:
            begin
                if (red_k_reg == kidx_t'(0))
                begin
                    red_k_next = K_FIRST;
                    if (!red_sel_reg)
                    begin
                        a_next       = NODE_W'(red_v);
                        red_val_next = UW'(b_raw_reg);
                        red_sel_next = 1'b1;
                    end
                    else
                    begin
                        b_next     = NODE_W'(red_v);
                        state_next = S_TA_RD;
                    end
                end
                else
                begin
                    red_val_next = red_v;
                    red_k_next   = red_k_reg - kidx_t'(1);
                end
            end
            S_TA_RD:
            begin
                fl_raddr   = a_reg;
                state_next = S_TA_WR;
            end
            S_TB_RD:
            begin
                fl_raddr   = b_reg;
                state_next = S_TB_WR;
            end
            S_TA_WR, S_TB_WR:
            begin
                fl_we = 1'b1;
                if (!fl_rdata[1])
                begin
                    pl_we         = 1'b1;
                    pl_waddr      = t_node;
                    pl_wdata      = t_node;
                    distinct_next = distinct_reg + cnt_t'(1);
                end
                odd_next = new_par ? (odd_reg + cnt_t'(1)) : (odd_reg - cnt_t'(1));
                if (state_reg == S_TA_WR)
                begin
                    state_next = S_TB_RD;
                end
                else
                begin
                    cur_next   = a_reg;
                    sel_next   = 1'b0;
                    state_next = S_F_RD;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_STEP;
            end
            S_F_STEP:
            begin
                pl_raddr = pl_rdata;
                if (ueq)
                begin
                    root_next  = cur_reg;
                    cur_next   = sel_reg ? b_reg : a_reg;
                    state_next = S_C_START;
                end
                else
                begin
                    cur_next = pl_rdata;
                end
            end
            S_C_START:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!sel_reg)
                    begin
                        ra_next    = root_reg;
                        sel_next   = 1'b1;
                        cur_next   = b_reg;
                        state_next = S_F_RD;
                    end
                    else
                    begin
                        state_next = S_UNION;
                    end
                end
                else
                begin
                    state_next = S_C_STEP;
                end
            end
            S_C_STEP:
            begin
                pl_we    = 1'b1;
                pl_raddr = pl_rdata;
                cur_next = pl_rdata;
                if (ueq)
                begin
                    if (!sel_reg)
                    begin
                        ra_next    = root_reg;
                        sel_next   = 1'b1;
                        cur_next   = b_reg;
                        state_next = S_F_RD;
                    end
                    else
                    begin
                        state_next = S_UNION;
                    end
                end
            end
            S_UNION:
            begin
                if (!ueq)
                begin
                    pl_we       = 1'b1;
                    pl_waddr    = ra_reg;
                    pl_wdata    = root_reg;
                    unions_next = unions_reg + cnt_t'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            red_val_reg  <= '0;
            red_k_reg    <= '0;
            red_sel_reg  <= 1'b0;
            b_raw_reg    <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            cur_reg      <= '0;
            root_reg     <= '0;
            ra_reg       <= '0;
            sel_reg      <= 1'b0;
            distinct_reg <= '0;
            unions_reg   <= '0;
            odd_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            red_val_reg  <= red_val_next;
            red_k_reg    <= red_k_next;
            red_sel_reg  <= red_sel_next;
            b_raw_reg    <= b_raw_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            cur_reg      <= cur_next;
            root_reg     <= root_next;
            ra_reg       <= ra_next;
            sel_reg      <= sel_next;
            distinct_reg <= distinct_next;
            unions_reg   <= unions_next;
            odd_reg      <= odd_next;
        end
    end

endmodule

### hw/rtl/euler_path_union_find_check.sv
// Euler path checker over a stream of undirected edges, kept by union-find.
// Each edge beat carries two node ids, end_a and end_b, on the edge channel
// (edge_valid, edge_stall). Each edge gives one result beat on the result
// channel (result_valid, result_stall): possible, components and odd_nodes.
// The block works on one edge at a time and holds edge_stall high meanwhile.
// The result beat and the next edge beat can each be taken at the earliest
// once the edge has gone through these steps in order: an update of the
// seen and parity flags of both ends, a find walk for each end with one find
// step and one compression step per parent link, a union step, a result
// step, and a pass through the output register or through the idle state.
// The parent link memory has a single read port. With path compression the
// walks stay short.
// A result waits in an output register, so the next edge is taken while the
// receiver stalls; the sequencer then holds its result until the register
// frees up. After reset the flag memory is cleared one entry per cycle,
// with edge_stall high; the counters start at zero.
// Depends on epuf_pkg and epuf_core.
`timescale 1ns / 1ps

module euler_path_union_find_check
    import epuf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            edge_valid,
    output logic            edge_stall,
    input  logic [ID_W-1:0] end_a,
    input  logic [ID_W-1:0] end_b,
    output logic            result_valid,
    input  logic            result_stall,
    output logic            possible,
    output cnt_t            components,
    output cnt_t            odd_nodes
);

    logic core_ready, core_res_valid, res_take;
    res_t core_res;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    epuf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .end_a      (end_a),
        .end_b      (end_b),
        .ready      (core_ready),
        .res_valid  (core_res_valid),
        .res        (core_res),
        .res_take   (res_take)
    );

    assign edge_stall = !core_ready;
    assign res_take   = core_res_valid && (!out_valid_reg || !result_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = core_res;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign possible     = out_reg.possible;
    assign components   = out_reg.components;
    assign odd_nodes    = out_reg.odd_nodes;

endmodule
